### rtl/core/lazy_fill_table_with_running_sum_top_assert.svh
// Assertion macros used by the checker of the table block.
`ifndef LAZY_FILL_TABLE_WITH_RUNNING_SUM_TOP_ASSERT_SVH
`define LAZY_FILL_TABLE_WITH_RUNNING_SUM_TOP_ASSERT_SVH

// Same-cycle implication, quiet while reset is held.
`define LFTS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("table block check failed");

// Next-cycle implication, quiet while reset is held.
`define LFTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("table block check failed");

`endif

### rtl/core/lfts_pkg.sv
package lfts_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int VALUE_BITS  = 32;
  localparam int INDEX_BITS  = $clog2(MAX_ENTRIES);
  localparam int COUNT_BITS  = 11;
  localparam int TOTAL_BITS  = 42;
  localparam int OP_BITS     = 2;
  localparam int EPOCH_BITS  = 8;

  localparam logic [COUNT_BITS-1:0] ENTRY_COUNT_RESET = COUNT_BITS'(1024);

  localparam logic [OP_BITS-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_ASSIGN = 2'd1;
  localparam logic [OP_BITS-1:0] OP_FILL   = 2'd2;

  // Epoch zero is kept for entries that were never written or were swept.
  localparam logic [EPOCH_BITS-1:0] EPOCH_NONE  = '0;
  localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
  localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

  typedef logic [EPOCH_BITS+VALUE_BITS-1:0] store_word_t;

endpackage

### rtl/core/lazy_fill_table_with_running_sum_top.sv
// Channel | Direction | Handshake           | Payload
// --------+-----------+---------------------+-------------------------------------------
// in_     | input     | in_valid / in_stall   | in_opcode, in_entry_index, in_new_value
// out_    | output    | out_valid / out_stall | out_total
// cfg_    | input     | cfg_wr_en             | cfg_entry_count (entry_count register)
//
// One transfer is taken per cycle while in_stall is low. Its result passes through stage one,
// where the registered read of the entry memory is made, then the result register, and waits
// there while out_stall is high.
// After reset the block sweeps all 1024 entries of the memory with in_stall high.
// Every 255th fill starts the same sweep, once its result has left stage one.
// out_stall holds the result register, and stage one behind it, then in_stall rises.
module lazy_fill_table_with_running_sum_top
  import lfts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_BITS-1:0]    in_opcode,
  input  logic [INDEX_BITS-1:0] in_entry_index,
  input  logic [VALUE_BITS-1:0] in_new_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TOTAL_BITS-1:0] out_total,
  input  logic                  cfg_wr_en,
  input  logic [COUNT_BITS-1:0] cfg_entry_count
);

  // Entry memory: each word carries the epoch it was written in, then the value.
  // A word whose epoch differs from the current one reads as unwritten, so a fill
  // only has to advance the epoch.
  store_word_t store_mem_r [MAX_ENTRIES];
  store_word_t rd_data_r;

  logic [COUNT_BITS-1:0] entry_count_r;
  logic [EPOCH_BITS-1:0] epoch_r;
  logic                  fill_active_r;
  logic [VALUE_BITS-1:0] fill_val_r;
  logic [TOTAL_BITS-1:0] total_r;
  logic [TOTAL_BITS-1:0] total_nxt;

  // Clearing sweep over the memory.
  logic                  sweep_r;
  logic [INDEX_BITS-1:0] sweep_addr_r;

  // Stage one: the item whose memory read is under way.
  logic                  s1_valid_r;
  logic [OP_BITS-1:0]    s1_op_r;
  logic [INDEX_BITS-1:0] s1_idx_r;
  logic [VALUE_BITS-1:0] s1_val_r;

  // Last item write, for a read issued in the same cycle.
  logic                  fwd_we_r;
  logic [INDEX_BITS-1:0] fwd_idx_r;
  logic [VALUE_BITS-1:0] fwd_val_r;

  logic                  out_valid_r;
  logic [TOTAL_BITS-1:0] out_total_r;

  logic                  out_free;
  logic                  s1_adv;
  logic                  s1_wrap;
  logic                  in_ready;
  logic                  in_xfer;
  logic [INDEX_BITS-1:0] rd_addr;
  logic                  s1_idx_ok;
  logic                  fwd_hit;
  logic [EPOCH_BITS-1:0] rd_tag;
  logic [VALUE_BITS-1:0] rd_val;
  logic [VALUE_BITS-1:0] old_val;
  logic [TOTAL_BITS-1:0] old_ext;
  logic [TOTAL_BITS-1:0] new_ext;
  logic [COUNT_BITS+VALUE_BITS-1:0] fill_prod;
  logic                  item_we;
  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_waddr;
  store_word_t           mem_wdata;

  // Handshake: stage one moves on when the result register is free or being taken.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  // A fill that wraps the epoch starts a sweep, so nothing may follow it into stage one.
  assign s1_wrap  = (s1_op_r == OP_FILL) && (epoch_r == EPOCH_LAST);
  assign in_ready = !sweep_r && (!s1_valid_r || (s1_adv && !s1_wrap));
  assign in_stall = !in_ready;
  assign in_xfer  = in_valid && in_ready;

  // Re-read for a held item, so its data is fresh once it can move.
  assign rd_addr = (s1_valid_r && !s1_adv) ? s1_idx_r : in_entry_index;

  assign s1_idx_ok = {{(COUNT_BITS-INDEX_BITS){1'b0}}, s1_idx_r} < entry_count_r;
  assign fwd_hit   = fwd_we_r && (fwd_idx_r == s1_idx_r);
  assign rd_tag    = rd_data_r[EPOCH_BITS+VALUE_BITS-1 -: EPOCH_BITS];
  assign rd_val    = rd_data_r[VALUE_BITS-1:0];

  // Current value of the entry: forwarded write, stored word of this epoch, else fill.
  always_comb begin
    if (fwd_hit) begin
      old_val = fwd_val_r;
    end else if (rd_tag == epoch_r) begin
      old_val = rd_val;
    end else if (fill_active_r) begin
      old_val = fill_val_r;
    end else begin
      old_val = '0;
    end
  end

  assign old_ext   = {{(TOTAL_BITS-VALUE_BITS){1'b0}}, old_val};
  assign new_ext   = {{(TOTAL_BITS-VALUE_BITS){1'b0}}, s1_val_r};
  assign fill_prod = {{VALUE_BITS{1'b0}}, entry_count_r} * {{COUNT_BITS{1'b0}}, s1_val_r};

  // New total and entry write for the item in stage one; totals wrap.
  always_comb begin
    total_nxt = total_r;
    item_we   = 1'b0;
    case (s1_op_r)
      OP_LOAD: begin
        if (s1_idx_ok) begin
          total_nxt = total_r + new_ext;
          item_we   = s1_adv;
        end
      end
      OP_ASSIGN: begin
        if (s1_idx_ok) begin
          total_nxt = total_r - old_ext + new_ext;
          item_we   = s1_adv;
        end
      end
      OP_FILL: begin
        total_nxt = fill_prod[TOTAL_BITS-1:0];
      end
      default: begin
        total_nxt = total_r;
      end
    endcase
  end

  // The sweep and items never share the write port: stage one is empty while sweeping.
  assign mem_we    = sweep_r || item_we;
  assign mem_waddr = sweep_r ? sweep_addr_r : s1_idx_r;
  assign mem_wdata = sweep_r ? {EPOCH_NONE, {VALUE_BITS{1'b0}}} : {epoch_r, s1_val_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem_r[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= store_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= ENTRY_COUNT_RESET;
      epoch_r       <= EPOCH_FIRST;
      fill_active_r <= 1'b0;
      fill_val_r    <= '0;
      total_r       <= '0;
      sweep_r       <= 1'b1;
      sweep_addr_r  <= '0;
      s1_valid_r    <= 1'b0;
      fwd_we_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        entry_count_r <= cfg_entry_count;
      end

      // Advance the sweep one entry a cycle; drop it after the last entry.
      if (sweep_r) begin
        sweep_addr_r <= sweep_addr_r + INDEX_BITS'(1);
        if (sweep_addr_r == INDEX_BITS'(MAX_ENTRIES-1)) begin
          sweep_r <= 1'b0;
        end
      end

      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      fwd_we_r <= item_we;

      if (s1_adv) begin
        total_r <= total_nxt;
        if (s1_op_r == OP_FILL) begin
          fill_active_r <= 1'b1;
          fill_val_r    <= s1_val_r;
          if (s1_wrap) begin
            epoch_r      <= EPOCH_FIRST;
            sweep_r      <= 1'b1;
            sweep_addr_r <= '0;
          end else begin
            epoch_r <= epoch_r + EPOCH_BITS'(1);
          end
        end
      end

      // Result register: load from stage one, else clear once taken.
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r  <= in_opcode;
      s1_idx_r <= in_entry_index;
      s1_val_r <= in_new_value;
    end
    if (item_we) begin
      fwd_idx_r <= s1_idx_r;
      fwd_val_r <= s1_val_r;
    end
    if (s1_adv) begin
      out_total_r <= total_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_total = out_total_r;

endmodule

### rtl/core/lfts_checker.sv
`include "lazy_fill_table_with_running_sum_top_assert.svh"

module lfts_checker
  import lfts_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [OP_BITS-1:0]    in_opcode,
  input logic [INDEX_BITS-1:0] in_entry_index,
  input logic [VALUE_BITS-1:0] in_new_value,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [TOTAL_BITS-1:0] out_total,
  input logic                  cfg_wr_en,
  input logic [COUNT_BITS-1:0] cfg_entry_count
);

  // A stalled result stays offered and unchanged.
  `LFTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `LFTS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_total))

  // The clearing sweep keeps the input stalled on the first cycle out of reset.
  `LFTS_ASSERT_IMPLIES(a_sweep_after_reset, clk, rst_n, !$past(rst_n), in_stall)

  // Every transfer in is followed by a result on offer, behind stage one and the result register.
  `LFTS_ASSERT_IMPLIES(a_result_follows, clk, rst_n, in_valid && !in_stall, ##2 out_valid)

endmodule

bind lazy_fill_table_with_running_sum_top lfts_checker u_lfts_checker (.*);

### sim/lfts_total_checker.sv
`timescale 1ns / 100ps
module lfts_total_checker
  import lfts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [OP_BITS-1:0]    in_opcode,
  input  logic [INDEX_BITS-1:0] in_entry_index,
  input  logic [VALUE_BITS-1:0] in_new_value,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [TOTAL_BITS-1:0] out_total,
  input  logic                  cfg_wr_en,
  input  logic [COUNT_BITS-1:0] cfg_entry_count,
  output int                    mismatches,
  output int                    totals_waiting,
  output int                    totals_seen
);

  logic [VALUE_BITS-1:0]  entry_val [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] entry_written = '0;
  logic                   fill_on = 1'b0;
  logic [VALUE_BITS-1:0]  fill_word = '0;
  logic [TOTAL_BITS-1:0]  sum_now = '0;
  logic [COUNT_BITS-1:0]  live_count = ENTRY_COUNT_RESET;
  logic [TOTAL_BITS-1:0]  totals_due [$];
  int                     errs = 0;
  int                     seen = 0;

  // Advance the table by one transfer and return the running total after it.
  function automatic logic [TOTAL_BITS-1:0] apply_transfer(
    input logic [OP_BITS-1:0]    op,
    input logic [INDEX_BITS-1:0] idx,
    input logic [VALUE_BITS-1:0] val
  );
    logic                  in_range;
    logic [VALUE_BITS-1:0] old;
    logic [63:0]           prod;
    in_range = {1'b0, idx} < live_count;
    // an unwritten entry reads as the fill value, or zero before any fill
    old  = entry_written[idx] ? entry_val[idx] : (fill_on ? fill_word : '0);
    prod = 64'(live_count) * 64'(val);
    case (op)
      OP_LOAD: begin
        if (in_range) begin
          entry_val[idx]     = val;
          entry_written[idx] = 1'b1;
          sum_now            = sum_now + TOTAL_BITS'(val);
        end
      end
      OP_ASSIGN: begin
        if (in_range) begin
          sum_now            = sum_now - TOTAL_BITS'(old) + TOTAL_BITS'(val);
          entry_val[idx]     = val;
          entry_written[idx] = 1'b1;
        end
      end
      OP_FILL: begin
        entry_written = '0;
        fill_on       = 1'b1;
        fill_word     = val;
        sum_now       = prod[TOTAL_BITS-1:0];
      end
      default: begin
      end
    endcase
    return sum_now;
  endfunction

  always @(posedge clk) begin
    logic [TOTAL_BITS-1:0] want;
    if (!rst_n) begin
      entry_written = '0;
      fill_on       = 1'b0;
      fill_word     = '0;
      sum_now       = '0;
      live_count    = ENTRY_COUNT_RESET;
      totals_due.delete();
    end else begin
      // check the result before taking a new transfer: a result never leaves in the same cycle as its transfer
      if (out_valid && !out_stall) begin
        if (totals_due.size() == 0) begin
          errs++;
          $display("%0t: total %0h arrived with nothing expected", $time, out_total);
        end else begin
          want = totals_due.pop_front();
          seen++;
          if (out_total !== want) begin
            errs++;
            $display("%0t: total mismatch, expected %0h, got %0h", $time, want, out_total);
          end
        end
      end
      if (cfg_wr_en)
        live_count = cfg_entry_count;
      if (in_valid && !in_stall)
        totals_due = {totals_due, apply_transfer(in_opcode, in_entry_index, in_new_value)};
    end
    mismatches     <= errs;
    totals_waiting <= totals_due.size();
    totals_seen    <= seen;
  end

endmodule

### sim/lazy_fill_table_with_running_sum_top_tb.sv
`timescale 1ns / 100ps
module lazy_fill_table_with_running_sum_top_tb;
  import lfts_pkg::*;

  // Opcode 3 is not used by the block; it must leave the total untouched.
  localparam logic [OP_BITS-1:0]    OP_UNUSED        = 2'd3;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX        = '1;
  localparam logic [INDEX_BITS-1:0] IDX_LAST         = INDEX_BITS'(MAX_ENTRIES - 1);
  localparam int                    LONG_HOLD_CYCLES = 64;

  typedef enum {MID_NONE, MID_HOLD, MID_PAUSE} mid_act_t;

  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic                  in_stall;
  logic [OP_BITS-1:0]    in_opcode       = OP_LOAD;
  logic [INDEX_BITS-1:0] in_entry_index  = '0;
  logic [VALUE_BITS-1:0] in_new_value    = '0;
  logic                  out_valid;
  logic                  out_stall       = 1'b0;
  logic [TOTAL_BITS-1:0] out_total;
  logic                  cfg_wr_en       = 1'b0;
  logic [COUNT_BITS-1:0] cfg_entry_count = ENTRY_COUNT_RESET;

  int mismatches;
  int totals_waiting;
  int totals_seen;

  // Idling knobs, in percent of cycles.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Long output hold-off: armed by the stimulus, counted by the receiver process.
  logic long_hold_go = 1'b0;
  int   hold_cycles  = 0;

  // Mirror of the entry_count register, used to aim indices at the live table.
  logic [COUNT_BITS-1:0] table_size = ENTRY_COUNT_RESET;
  int fills_sent     = 0;
  int transfers_sent = 0;
  int sizes_used     = 0;

  always #6 clk = ~clk;

  lazy_fill_table_with_running_sum_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_entry_index  (in_entry_index),
    .in_new_value    (in_new_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_total       (out_total),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_entry_count (cfg_entry_count)
  );

  lfts_total_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_entry_index  (in_entry_index),
    .in_new_value    (in_new_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_total       (out_total),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_entry_count (cfg_entry_count),
    .mismatches      (mismatches),
    .totals_waiting  (totals_waiting),
    .totals_seen     (totals_seen)
  );

  // Receiver: stall at random, or hold the output off for one long stretch once
  // armed, so the pipeline backs up and in_stall has to rise.
  always @(posedge clk) begin
    if (long_hold_go && hold_cycles < LONG_HOLD_CYCLES) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Safety net: a hung handshake must not run forever.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Offer one transfer and hold it steady until the block takes it. Random idle
  // cycles go in front; valid is never lowered and raised in the same step.
  task automatic send_item(input logic [OP_BITS-1:0] op, input logic [INDEX_BITS-1:0] idx,
                           input logic [VALUE_BITS-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_entry_index <= idx;
    in_new_value   <= val;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    transfers_sent++;
    if (op == OP_FILL)
      fills_sent++;
  endtask

  // Drop valid and wait until every expected total has come back.
  task automatic settle();
    in_valid <= 1'b0;
    do
      @(posedge clk);
    while (totals_waiting != 0);
  endtask

  // Write entry_count only with the block idle; allow a few cycles of slack first.
  task automatic set_table_size(input logic [COUNT_BITS-1:0] size);
    settle();
    repeat (3) @(posedge clk);
    cfg_wr_en       <= 1'b1;
    cfg_entry_count <= size;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    table_size = size;
    sizes_used++;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // Random transfers: loads and assigns inside the table and a share of fills set by
  // fill_pct, a bias to a few hot entries so assigns revisit written ones, and a
  // little noise (unused opcode, indices past the table). Only transfers that
  // change something count towards the target.
  task automatic random_phase(input int target, input int fill_pct, input mid_act_t mid);
    int                    useful;
    int                    pick;
    logic [OP_BITS-1:0]    op;
    logic [INDEX_BITS-1:0] idx;
    logic [VALUE_BITS-1:0] val;
    useful = 0;
    while (useful < target) begin
      pick = $urandom_range(99);
      if (pick < fill_pct)
        op = OP_FILL;
      else if (pick < 97)
        op = $urandom_range(1) ? OP_ASSIGN : OP_LOAD;
      else
        op = OP_UNUSED;

      pick = $urandom_range(9);
      if (table_size == 0 || pick == 0)
        idx = INDEX_BITS'($urandom);
      else if (pick < 5)
        idx = INDEX_BITS'($urandom_range(table_size > 8 ? 7 : int'(table_size) - 1));
      else
        idx = INDEX_BITS'($urandom_range(int'(table_size) - 1));

      pick = $urandom_range(9);
      if (pick == 0)
        val = '0;
      else if (pick == 1)
        val = VALUE_MAX;
      else
        val = VALUE_BITS'($urandom);

      send_item(op, idx, val);
      if (op == OP_FILL || (op != OP_UNUSED && {1'b0, idx} < table_size))
        useful++;

      if (useful == target / 2) begin
        if (mid == MID_HOLD)
          long_hold_go <= 1'b1;
        else if (mid == MID_PAUSE)
          settle();
        // fire once per phase
        mid = MID_NONE;
      end
    end
  endtask

  initial begin
    int wait_cycles;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, full table: extremes, every opcode, lazy fill behaviour.
    set_table_size(COUNT_BITS'(1024));
    send_item(OP_LOAD,   '0,       VALUE_MAX);      // load at the lowest index
    send_item(OP_LOAD,   IDX_LAST, '0);             // load zero at the highest index
    send_item(OP_ASSIGN, '0,       32'h0000_1234);  // assign over a written entry
    send_item(OP_ASSIGN, 10'd7,    32'd5);          // assign to an entry never written
    send_item(OP_UNUSED, IDX_LAST, VALUE_MAX);      // unused opcode: total unchanged
    send_item(OP_FILL,   IDX_LAST, VALUE_MAX);      // fill, total near the wrap point
    send_item(OP_ASSIGN, IDX_LAST, '0);             // unwritten entry reads the fill value
    send_item(OP_ASSIGN, IDX_LAST, 32'd9);          // a written zero still counts as written
    send_item(OP_LOAD,   10'd2,    VALUE_MAX);      // load after fill: no subtraction
    send_item(OP_FILL,   10'd0,    '0);             // fill with zero
    send_item(OP_ASSIGN, 10'd500,  32'h8000_0000);
    send_item(OP_LOAD,   IDX_LAST, VALUE_MAX);
    send_item(OP_LOAD,   IDX_LAST, VALUE_MAX);

    // Small table: indices past the end must change nothing.
    set_table_size(COUNT_BITS'(3));
    send_item(OP_LOAD,   10'd3,    32'd77);
    send_item(OP_ASSIGN, IDX_LAST, 32'd77);
    send_item(OP_LOAD,   10'd2,    32'd5);
    send_item(OP_FILL,   10'd1,    32'hA5A5_5A5A);
    send_item(OP_ASSIGN, 10'd2,    32'd7);
    send_item(OP_ASSIGN, 10'd0,    VALUE_MAX);

    // Zero count: a fill gives zero and every index is out of range.
    set_table_size('0);
    send_item(OP_FILL,   10'd0,    VALUE_MAX);
    send_item(OP_ASSIGN, 10'd0,    32'd5);

    // Random phases: table sizes from one entry to the full table, idling varied.
    set_table_size(COUNT_BITS'(1024));
    set_idling(0, 0);
    random_phase(90, 20, MID_HOLD);

    set_table_size(COUNT_BITS'(16));
    set_idling(81, 0);
    random_phase(60, 60, MID_NONE);

    set_table_size(COUNT_BITS'(1024));
    set_idling(0, 81);
    random_phase(70, 30, MID_NONE);

    set_table_size(COUNT_BITS'(5));
    set_idling(25, 25);
    random_phase(80, 60, MID_PAUSE);

    set_table_size(COUNT_BITS'(1));
    set_idling(0, 0);
    random_phase(40, 70, MID_NONE);

    set_table_size(COUNT_BITS'(600));
    set_idling(25, 25);
    random_phase(70, 60, MID_NONE);

    set_table_size(COUNT_BITS'(1024));
    set_idling(0, 0);
    random_phase(100, 80, MID_NONE);

    // Drain with a bound, then leave room for any stray result to show up.
    in_valid <= 1'b0;
    wait_cycles = 0;
    do begin
      @(posedge clk);
      wait_cycles++;
    end while (totals_waiting != 0 && wait_cycles < 20000);
    repeat (8) @(posedge clk);

    if (totals_waiting != 0)
      $display("%0t: %0d expected totals never arrived", $time, totals_waiting);
    $display("Covered %0d transfers (%0d fills), %0d totals checked, %0d table sizes.",
             transfers_sent, fills_sent, totals_seen, sizes_used);
    $display("Idling: none, sender gaps, receiver stalls, both, plus a %0d-cycle hold-off.",
             LONG_HOLD_CYCLES);
    if (mismatches == 0 && totals_waiting == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/lfts_pkg.sv
rtl/core/lazy_fill_table_with_running_sum_top.sv
rtl/core/lfts_checker.sv
sim/lfts_total_checker.sv
sim/lazy_fill_table_with_running_sum_top_tb.sv
